@@ rtl/bfa_pkg.sv @@
`default_nettype none
package bfa_pkg;

    // memory geometry
    localparam int UNITS        = 1024;
    localparam int MAX_REQUESTS = 1024;
    localparam int UNIT_W       = $clog2(UNITS + 1);
    localparam int REQ_W        = $clog2(MAX_REQUESTS + 1);
    localparam int FIELD_W      = 11;
    localparam int CLR_LAST     = (UNITS > MAX_REQUESTS) ? UNITS : MAX_REQUESTS;
    localparam int CLR_W        = $clog2(CLR_LAST + 1);

    // request kinds
    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE  = 1'b1;

    typedef logic [UNIT_W-1:0] unit_t;
    typedef logic [REQ_W-1:0]  req_t;

    // one entry of the block table, indexed by unit
    typedef struct packed {
        unit_t last;
        logic  is_start;
        logic  is_free;
    } mem_word_t;

    typedef enum logic [4:0] {
        ST_CLEAR, ST_IDLE, ST_SCAN, ST_DECIDE, ST_SPLIT, ST_TAKE, ST_ALOG,
        ST_FREAD, ST_FLOG, ST_RCHK, ST_RNEXT, ST_RNCLR, ST_RPREV0, ST_RPREV,
        ST_RSCLR, ST_FITEM
    } ctrl_state_t;

    typedef enum logic [3:0] {
        OP_NONE, OP_CLEAR, OP_LOAD, OP_SCAN, OP_SPLIT, OP_TAKE, OP_ALOG,
        OP_FREAD, OP_FLOG, OP_RCHK, OP_RNEXT, OP_RNCLR, OP_RPREV0, OP_RPREV,
        OP_RSCLR, OP_FITEM
    } dp_op_t;

    typedef struct packed {
        dp_op_t op;
    } ctrl_cmd_t;

    typedef struct packed {
        logic clr_done;
        logic scan_more;
        logic found;
        logic split;
        logic req_ok;
        logic s_ok;
        logic rel_go;
        logic n_ok;
        logic n_merge;
        logic s_gt1;
        logic p_walk;
        logic p_free;
        logic out_free;
    } dp_status_t;

    // last unit of the block at s, forced into s..total
    function automatic unit_t bfa_end(input unit_t last, input unit_t s, input unit_t total);
        bfa_end = (last < s || last > total) ? total : last;
    endfunction

endpackage
`default_nettype wire

@@ rtl/best_fit_block_allocator_top.sv @@
// Allocate: a best-fit scan of one block per cycle over the table, then decide,
//   an optional split, take and log; the log step waits while a result is held.
// Free: log read and checks, merge with the next block, then a backward walk of one
//   unit per cycle to the previous block start (at most UNITS). One request is worked at a time.
// Reset (aresetn low, synchronous) and every register write start a clearing
//   pass over table and log; no request is taken during it.
`default_nettype none
module best_fit_block_allocator_top (
    input  wire  logic        aclk,
    input  wire  logic        aresetn,
    input  wire  logic        cfg_wr_en,
    input  wire  logic [10:0] cfg_wr_data,   // total_units
    input  wire  logic        s_tvalid,
    output logic              s_tready,
    input  wire  logic [23:0] s_tdata,       // alloc_size[10:0], request_number[21:11]
    input  wire  logic [0:0]  s_tuser,       // cmd[0]
    output logic              m_tvalid,
    input  wire  logic        m_tready,
    output logic [15:0]       m_tdata,       // start_address[10:0]
    output logic [0:0]        m_tuser        // granted[0]
);

    bfa_pkg::ctrl_cmd_t  cmd;
    bfa_pkg::dp_status_t status;
    logic                granted;
    logic [10:0]         start_address;

    bfa_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .s_tvalid  (s_tvalid),
        .in_cmd    (s_tuser[0]),
        .s_tready  (s_tready),
        .status    (status),
        .cmd       (cmd)
    );

    bfa_dpath u_dpath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_size     (s_tdata[10:0]),
        .in_req      (s_tdata[21:11]),
        .m_tready    (m_tready),
        .m_tvalid    (m_tvalid),
        .out_granted (granted),
        .out_start   (start_address),
        .cmd         (cmd),
        .status      (status)
    );

    assign m_tdata = {5'b0, start_address};
    assign m_tuser = granted;

endmodule
`default_nettype wire

@@ rtl/bfa_ram.sv @@
`default_nettype none
module bfa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire  logic                     aclk,
    input  wire  logic                     wr_en,
    input  wire  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire  logic [WIDTH-1:0]         wr_data,
    input  wire  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic       [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // one write port, one registered read port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule
`default_nettype wire

@@ rtl/bfa_ctrl.sv @@
`default_nettype none
module bfa_ctrl (
    input  wire  logic               aclk,
    input  wire  logic               aresetn,
    input  wire  logic               cfg_wr_en,
    input  wire  logic               s_tvalid,
    input  wire  logic               in_cmd,
    output logic                     s_tready,
    input  wire  bfa_pkg::dp_status_t status,
    output bfa_pkg::ctrl_cmd_t       cmd
);

    bfa_pkg::ctrl_state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= bfa_pkg::ST_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

    // next state and datapath command
    always_comb begin
        state_next = state_reg;
        cmd.op     = bfa_pkg::OP_NONE;
        s_tready   = 1'b0;
        case (state_reg)
            bfa_pkg::ST_CLEAR: begin
                cmd.op = bfa_pkg::OP_CLEAR;
                if (status.clr_done) state_next = bfa_pkg::ST_IDLE;
            end
            bfa_pkg::ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.op     = bfa_pkg::OP_LOAD;
                    state_next = (in_cmd == bfa_pkg::CMD_FREE) ? bfa_pkg::ST_FREAD
                                                               : bfa_pkg::ST_SCAN;
                end
            end
            bfa_pkg::ST_SCAN: begin
                cmd.op = bfa_pkg::OP_SCAN;
                if (!status.scan_more) state_next = bfa_pkg::ST_DECIDE;
            end
            bfa_pkg::ST_DECIDE: begin
                if (!status.found)     state_next = bfa_pkg::ST_ALOG;
                else if (status.split) state_next = bfa_pkg::ST_SPLIT;
                else                   state_next = bfa_pkg::ST_TAKE;
            end
            bfa_pkg::ST_SPLIT: begin
                cmd.op     = bfa_pkg::OP_SPLIT;
                state_next = bfa_pkg::ST_TAKE;
            end
            bfa_pkg::ST_TAKE: begin
                cmd.op     = bfa_pkg::OP_TAKE;
                state_next = bfa_pkg::ST_ALOG;
            end
            bfa_pkg::ST_ALOG: begin
                if (status.out_free) begin
                    cmd.op     = bfa_pkg::OP_ALOG;
                    state_next = bfa_pkg::ST_IDLE;
                end
            end
            bfa_pkg::ST_FREAD: begin
                cmd.op     = bfa_pkg::OP_FREAD;
                state_next = status.req_ok ? bfa_pkg::ST_FLOG : bfa_pkg::ST_FITEM;
            end
            bfa_pkg::ST_FLOG: begin
                cmd.op     = bfa_pkg::OP_FLOG;
                state_next = status.s_ok ? bfa_pkg::ST_RCHK : bfa_pkg::ST_FITEM;
            end
            bfa_pkg::ST_RCHK: begin
                cmd.op = bfa_pkg::OP_RCHK;
                if (!status.rel_go)   state_next = bfa_pkg::ST_FITEM;
                else if (status.n_ok) state_next = bfa_pkg::ST_RNEXT;
                else                  state_next = bfa_pkg::ST_RPREV0;
            end
            bfa_pkg::ST_RNEXT: begin
                cmd.op     = bfa_pkg::OP_RNEXT;
                state_next = status.n_merge ? bfa_pkg::ST_RNCLR : bfa_pkg::ST_RPREV0;
            end
            bfa_pkg::ST_RNCLR: begin
                cmd.op     = bfa_pkg::OP_RNCLR;
                state_next = bfa_pkg::ST_RPREV0;
            end
            bfa_pkg::ST_RPREV0: begin
                cmd.op     = bfa_pkg::OP_RPREV0;
                state_next = status.s_gt1 ? bfa_pkg::ST_RPREV : bfa_pkg::ST_FITEM;
            end
            bfa_pkg::ST_RPREV: begin
                cmd.op = bfa_pkg::OP_RPREV;
                if (!status.p_walk) begin
                    state_next = status.p_free ? bfa_pkg::ST_RSCLR : bfa_pkg::ST_FITEM;
                end
            end
            bfa_pkg::ST_RSCLR: begin
                cmd.op     = bfa_pkg::OP_RSCLR;
                state_next = bfa_pkg::ST_FITEM;
            end
            bfa_pkg::ST_FITEM: begin
                cmd.op     = bfa_pkg::OP_FITEM;
                state_next = bfa_pkg::ST_IDLE;
            end
            default: state_next = bfa_pkg::ST_CLEAR;
        endcase
        // a register write rebuilds the table
        if (cfg_wr_en) state_next = bfa_pkg::ST_CLEAR;
    end

endmodule
`default_nettype wire

@@ rtl/bfa_dpath.sv @@
`default_nettype none
module bfa_dpath (
    input  wire  logic                          aclk,
    input  wire  logic                          aresetn,
    input  wire  logic                          cfg_wr_en,
    input  wire  logic [bfa_pkg::FIELD_W-1:0]   cfg_wr_data,
    input  wire  logic [bfa_pkg::FIELD_W-1:0]   in_size,
    input  wire  logic [bfa_pkg::FIELD_W-1:0]   in_req,
    input  wire  logic                          m_tready,
    output logic                                m_tvalid,
    output logic                                out_granted,
    output logic       [bfa_pkg::FIELD_W-1:0]   out_start,
    input  wire  bfa_pkg::ctrl_cmd_t            cmd,
    output bfa_pkg::dp_status_t                 status
);

    localparam int MW = $bits(bfa_pkg::mem_word_t);

    bfa_pkg::unit_t total_reg, total_next;
    logic [bfa_pkg::CLR_W-1:0] clr_reg;
    bfa_pkg::unit_t size_reg, cur_reg, best_reg, best_size_reg, best_end_reg;
    bfa_pkg::unit_t end_reg, nb_reg, p_reg;
    logic [bfa_pkg::FIELD_W-1:0] req_reg;
    bfa_pkg::req_t cnt_reg, item_reg;
    logic out_valid_reg, out_granted_reg;
    bfa_pkg::unit_t out_start_reg;

    // table and log memories
    logic            mem_we, log_we;
    bfa_pkg::unit_t  mem_waddr, mem_raddr;
    bfa_pkg::mem_word_t mem_wdata, word;
    logic [MW-1:0]   mem_rbits;
    bfa_pkg::req_t   log_waddr, log_raddr;
    bfa_pkg::unit_t  log_wdata, log_rdata;

    bfa_ram #(.WIDTH(MW), .DEPTH(bfa_pkg::UNITS + 1)) u_mem (
        .aclk    (aclk),
        .wr_en   (mem_we),
        .wr_addr (mem_waddr),
        .wr_data (mem_wdata),
        .rd_addr (mem_raddr),
        .rd_data (mem_rbits)
    );

    bfa_ram #(.WIDTH(bfa_pkg::UNIT_W), .DEPTH(bfa_pkg::MAX_REQUESTS + 1)) u_log (
        .aclk    (aclk),
        .wr_en   (log_we),
        .wr_addr (log_waddr),
        .wr_data (log_wdata),
        .rd_addr (log_raddr),
        .rd_data (log_rdata)
    );

    assign word = bfa_pkg::mem_word_t'(mem_rbits);

    // scan and release arithmetic
    bfa_pkg::unit_t e_cur, len_cur, nxt_cur, e_nb, split_at;
    logic fit;

    always_comb begin
        e_cur    = bfa_pkg::bfa_end(word.last, cur_reg, total_reg);
        len_cur  = e_cur - cur_reg + bfa_pkg::UNIT_W'(1);
        nxt_cur  = e_cur + bfa_pkg::UNIT_W'(1);
        e_nb     = bfa_pkg::bfa_end(word.last, nb_reg, total_reg);
        split_at = best_reg + size_reg;
        fit      = word.is_free && (len_cur >= size_reg) && (size_reg != '0)
                   && ((best_reg == '0) || (len_cur < best_size_reg));
    end

    // status toward the controller
    always_comb begin
        status.clr_done  = (clr_reg == bfa_pkg::CLR_W'(bfa_pkg::CLR_LAST));
        status.scan_more = (nxt_cur <= total_reg);
        status.found     = (best_reg != '0);
        status.split     = (best_size_reg > size_reg);
        status.req_ok    = (req_reg != '0) && (32'(req_reg) <= 32'(cnt_reg))
                           && (32'(req_reg) <= 32'(bfa_pkg::MAX_REQUESTS))
                           && (32'(req_reg) != 32'(item_reg));
        status.s_ok      = (log_rdata != '0) && (log_rdata <= total_reg);
        status.rel_go    = word.is_start && !word.is_free;
        status.n_ok      = (nxt_cur <= total_reg);
        status.n_merge   = word.is_start && word.is_free;
        status.s_gt1     = (cur_reg > bfa_pkg::UNIT_W'(1));
        status.p_walk    = (p_reg > bfa_pkg::UNIT_W'(1)) && !word.is_start;
        status.p_free    = word.is_free;
        status.out_free  = !out_valid_reg || m_tready;
    end

    // memory port selection
    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = cur_reg;
        mem_wdata = '{last: end_reg, is_start: 1'b1, is_free: 1'b1};
        mem_raddr = '0;
        log_we    = 1'b0;
        log_waddr = item_reg;
        log_wdata = '0;
        log_raddr = bfa_pkg::REQ_W'(req_reg);
        case (cmd.op)
            bfa_pkg::OP_CLEAR: begin
                mem_we    = (32'(clr_reg) <= 32'(bfa_pkg::UNITS));
                mem_waddr = bfa_pkg::UNIT_W'(clr_reg);
                // unit 1 opens the one free block, the rest are interior
                if (clr_reg == bfa_pkg::CLR_W'(1)) begin
                    mem_wdata = '{last: total_reg, is_start: 1'b1, is_free: 1'b1};
                end else begin
                    mem_wdata = '{last: '0, is_start: 1'b0, is_free: 1'b1};
                end
                log_we    = (32'(clr_reg) <= 32'(bfa_pkg::MAX_REQUESTS));
                log_waddr = bfa_pkg::REQ_W'(clr_reg);
            end
            bfa_pkg::OP_LOAD:   mem_raddr = bfa_pkg::UNIT_W'(1);
            bfa_pkg::OP_SCAN:   mem_raddr = nxt_cur;
            bfa_pkg::OP_SPLIT: begin
                mem_we    = 1'b1;
                mem_waddr = split_at;
                mem_wdata = '{last: best_end_reg, is_start: 1'b1, is_free: 1'b1};
            end
            bfa_pkg::OP_TAKE: begin
                mem_we    = 1'b1;
                mem_waddr = best_reg;
                mem_wdata = '{last: status.split ? split_at - bfa_pkg::UNIT_W'(1)
                                                 : best_end_reg,
                              is_start: 1'b1, is_free: 1'b0};
            end
            bfa_pkg::OP_ALOG: begin
                log_we    = (item_reg != '0);
                log_wdata = best_reg;
            end
            bfa_pkg::OP_FLOG: begin
                log_we    = 1'b1;
                log_waddr = bfa_pkg::REQ_W'(req_reg);
                mem_raddr = log_rdata;
            end
            bfa_pkg::OP_RCHK: begin
                mem_we    = status.rel_go;
                mem_wdata = '{last: word.last, is_start: 1'b1, is_free: 1'b1};
                mem_raddr = nxt_cur;
            end
            bfa_pkg::OP_RNEXT: begin
                mem_we    = status.n_merge;
                mem_wdata = '{last: e_nb, is_start: 1'b1, is_free: 1'b1};
            end
            bfa_pkg::OP_RNCLR: begin
                mem_we    = 1'b1;
                mem_waddr = nb_reg;
                mem_wdata = '{last: end_reg, is_start: 1'b0, is_free: 1'b1};
            end
            bfa_pkg::OP_RPREV0: mem_raddr = cur_reg - bfa_pkg::UNIT_W'(1);
            bfa_pkg::OP_RPREV: begin
                mem_raddr = p_reg - bfa_pkg::UNIT_W'(1);
                mem_we    = !status.p_walk && status.p_free;
                mem_waddr = p_reg;
            end
            bfa_pkg::OP_RSCLR: begin
                mem_we    = 1'b1;
                mem_wdata = '{last: end_reg, is_start: 1'b0, is_free: 1'b1};
            end
            bfa_pkg::OP_FITEM: log_we = (item_reg != '0);
            default: mem_we = 1'b0;
        endcase
    end

    // register value clamped into 1..UNITS
    always_comb begin
        if (cfg_wr_data == '0) begin
            total_next = bfa_pkg::UNIT_W'(1);
        end else if (32'(cfg_wr_data) > 32'(bfa_pkg::UNITS)) begin
            total_next = bfa_pkg::UNIT_W'(bfa_pkg::UNITS);
        end else begin
            total_next = bfa_pkg::UNIT_W'(cfg_wr_data);
        end
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            total_reg     <= bfa_pkg::UNIT_W'(bfa_pkg::UNITS);
            clr_reg       <= '0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                total_reg <= total_next;
                clr_reg   <= '0;
            end else if (cmd.op == bfa_pkg::OP_CLEAR && !status.clr_done) begin
                clr_reg <= clr_reg + bfa_pkg::CLR_W'(1);
            end
            if (cmd.op == bfa_pkg::OP_LOAD
                && 32'(cnt_reg) < 32'(bfa_pkg::MAX_REQUESTS)) begin
                cnt_reg <= cnt_reg + bfa_pkg::REQ_W'(1);
            end
            if (cmd.op == bfa_pkg::OP_ALOG) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        case (cmd.op)
            bfa_pkg::OP_LOAD: begin
                size_reg      <= bfa_pkg::UNIT_W'(in_size);
                req_reg       <= in_req;
                cur_reg       <= bfa_pkg::UNIT_W'(1);
                best_reg      <= '0;
                best_size_reg <= '0;
                item_reg      <= (32'(cnt_reg) < 32'(bfa_pkg::MAX_REQUESTS))
                                 ? cnt_reg + bfa_pkg::REQ_W'(1) : '0;
            end
            bfa_pkg::OP_SCAN: begin
                if (fit) begin
                    best_reg      <= cur_reg;
                    best_size_reg <= len_cur;
                    best_end_reg  <= e_cur;
                end
                cur_reg <= nxt_cur;
            end
            bfa_pkg::OP_ALOG: begin
                out_granted_reg <= (best_reg != '0);
                out_start_reg   <= best_reg;
            end
            bfa_pkg::OP_FLOG: cur_reg <= log_rdata;
            bfa_pkg::OP_RCHK: begin
                end_reg <= e_cur;
                nb_reg  <= nxt_cur;
            end
            bfa_pkg::OP_RNEXT: begin
                if (status.n_merge) end_reg <= e_nb;
            end
            bfa_pkg::OP_RPREV0: p_reg <= cur_reg - bfa_pkg::UNIT_W'(1);
            bfa_pkg::OP_RPREV: begin
                if (status.p_walk) p_reg <= p_reg - bfa_pkg::UNIT_W'(1);
            end
            default: ;
        endcase
    end

    assign m_tvalid    = out_valid_reg;
    assign out_granted = out_granted_reg;
    assign out_start   = bfa_pkg::FIELD_W'(out_start_reg);

endmodule
`default_nettype wire

@@ bench/tb_top.sv @@
`default_nettype none
// Shadow model of the allocator plus the queue of grants still to come.
class alloc_scoreboard;
    int unsigned total;
    int unsigned last_u[bfa_pkg::UNITS+1];
    bit          is_start[bfa_pkg::UNITS+1];
    bit          is_free[bfa_pkg::UNITS+1];
    int unsigned start_log[bfa_pkg::MAX_REQUESTS+1];
    int unsigned item_cnt;
    bit          want_grant[$];
    int unsigned want_start[$];
    int          mismatches;
    int          grants_seen;
    int          refusals_seen;

    function new();
        total = bfa_pkg::UNITS;
        item_cnt = 0;
        mismatches = 0;
        grants_seen = 0;
        refusals_seen = 0;
        clear_memory();
    endfunction

    function void clear_memory();
        for (int i = 0; i <= bfa_pkg::UNITS; i++) begin
            last_u[i] = 0;
            is_start[i] = 0;
            is_free[i] = 1;
        end
        last_u[1] = total;
        is_start[1] = 1;
        for (int i = 0; i <= bfa_pkg::MAX_REQUESTS; i++)
            start_log[i] = 0;
    endfunction

    function void set_total(logic [10:0] value);
        total = (value == 0) ? 1 : (value > bfa_pkg::UNITS) ? bfa_pkg::UNITS : value;
        clear_memory();
    endfunction

    function int unsigned end_of(int unsigned s);
        int unsigned e;
        e = last_u[s];
        if (e < s || e > total)
            e = total;
        return e;
    endfunction

    // best fit, lowest address on a tie
    function int unsigned take_block(int unsigned size);
        int unsigned s, e, len, best, best_len, r;
        s = 1;
        best = 0;
        best_len = 0;
        if (size == 0)
            return 0;
        while (s <= total) begin
            e = end_of(s);
            len = e - s + 1;
            if (is_free[s] && len >= size && (best == 0 || len < best_len)) begin
                best = s;
                best_len = len;
            end
            s = e + 1;
        end
        if (best == 0)
            return 0;
        if (best_len > size) begin
            r = best + size;
            last_u[r] = end_of(best);
            is_start[r] = 1;
            is_free[r] = 1;
            last_u[best] = r - 1;
        end
        is_free[best] = 0;
        return best;
    endfunction

    // free and merge with free neighbors
    function void give_back(int unsigned s);
        int unsigned n, p;
        if (s < 1 || s > total || !is_start[s] || is_free[s])
            return;
        is_free[s] = 1;
        n = end_of(s) + 1;
        if (n <= total && is_start[n] && is_free[n]) begin
            last_u[s] = end_of(n);
            is_start[n] = 0;
        end
        if (s > 1) begin
            p = s - 1;
            while (p > 1 && !is_start[p])
                p--;
            if (is_free[p]) begin
                last_u[p] = end_of(s);
                is_start[s] = 0;
            end
        end
    endfunction

    // note an accepted request
    function void note_request(logic cmd, logic [10:0] size, logic [10:0] req);
        int unsigned item, st;
        item = 0;
        if (item_cnt < bfa_pkg::MAX_REQUESTS) begin
            item_cnt++;
            item = item_cnt;
        end
        if (cmd == bfa_pkg::CMD_FREE) begin
            if (req >= 1 && req <= item_cnt && req != item) begin
                st = start_log[req];
                start_log[req] = 0;
                if (st != 0)
                    give_back(st);
            end
            if (item != 0)
                start_log[item] = 0;
        end else begin
            st = take_block(size);
            if (item != 0)
                start_log[item] = st;
            want_grant.push_back(st != 0);
            want_start.push_back(st);
        end
    endfunction

    // compare one result with the oldest expectation
    function void check_result(logic granted, logic [10:0] start);
        bit eg;
        int unsigned es;
        if (want_grant.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
                $display("unexpected result: granted=%0d start=%0d", granted, start);
            return;
        end
        eg = want_grant.pop_front();
        es = want_start.pop_front();
        if (eg) grants_seen++; else refusals_seen++;
        if (granted !== eg || start !== es[10:0]) begin
            mismatches++;
            if (mismatches <= 10)
                $display("result mismatch: expected granted=%0d start=%0d, %s%0d start=%0d",
                         eg, es, "got granted=", granted, start);
        end
    endfunction

    function int pending();
        return want_grant.size();
    endfunction
endclass

module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 3000000;
    localparam int SETTLE      = 1100;

    logic        aclk = 0;
    logic        aresetn = 0;
    logic        cfg_wr_en = 0;
    logic [10:0] cfg_wr_data = 0;
    logic        s_tvalid = 0;
    logic        s_tready;
    logic [23:0] s_tdata = 0;
    logic [0:0]  s_tuser = 0;
    logic        m_tvalid;
    logic        m_tready = 0;
    logic [15:0] m_tdata;
    logic [0:0]  m_tuser;

    logic [10:0] totals[7] = '{11'd37, 11'd1, 11'd0, 11'd2047, 11'd200, 11'd5, 11'd1024};

    alloc_scoreboard sb = new();
    int  cycles = 0;
    bit  calm = 0;
    int  sent = 0;

    best_fit_block_allocator_top u_dut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
    );

    always #4 aclk = ~aclk;

    // watchdog
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("tb_top failed");
            $finish;
        end
    end

    // result side: random stall, then take one result
    initial begin
        int stall;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            stall = calm ? 0 : $urandom_range(0, 18);
            if (stall > 0) begin
                m_tready <= 0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1;
            do @(posedge aclk); while (!m_tvalid);
            sb.check_result(m_tuser[0], m_tdata[10:0]);
        end
    end

    task automatic send_request(logic cmd, logic [10:0] size, logic [10:0] req);
        int gap;
        gap = calm ? 0 : $urandom_range(0, 18);
        if (gap > 0) begin
            s_tvalid <= 0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1;
        s_tuser  <= cmd;
        s_tdata  <= {2'b0, req, size};
        do @(posedge aclk); while (!s_tready);
        sb.note_request(cmd, size, req);
        sent++;
    endtask

    task automatic drain();
        s_tvalid <= 0;
        while (sb.pending() != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    task automatic write_total(logic [10:0] value);
        drain();
        cfg_wr_en   <= 1;
        cfg_wr_data <= value;
        @(posedge aclk);
        cfg_wr_en   <= 0;
        sb.set_total(value);
    endtask

    // one random request: mostly sensible allocs and frees of live blocks
    task automatic random_request();
        int unsigned pick, lim;
        int unsigned live[$];
        logic [10:0] size;
        pick = $urandom_range(0, 99);
        lim = (sb.total / 4 < 1) ? 1 : sb.total / 4;
        if (pick < 52) begin
            case ($urandom_range(0, 19))
                0:       size = 11'd0;
                1, 2:    size = 11'($urandom_range(0, 2047));
                3, 4, 5: size = 11'($urandom_range(1, sb.total));
                default: size = 11'($urandom_range(1, lim));
            endcase
            send_request(bfa_pkg::CMD_ALLOC, size, 11'($urandom_range(0, 2047)));
        end else if (pick < 90) begin
            for (int k = 1; k <= sb.item_cnt; k++)
                if (sb.start_log[k] != 0) live.push_back(k);
            if (live.size() == 0)
                send_request(bfa_pkg::CMD_ALLOC, 11'($urandom_range(1, lim)),
                             11'($urandom_range(0, 2047)));
            else
                send_request(bfa_pkg::CMD_FREE, 11'($urandom_range(0, 2047)),
                             11'(live[$urandom_range(0, live.size() - 1)]));
        end else begin
            send_request(bfa_pkg::CMD_FREE, 11'($urandom_range(0, 2047)),
                         11'($urandom_range(0, 2047)));
        end
    endtask

    initial begin
        repeat (5) @(posedge aclk);
        aresetn <= 1;

        // directed: edge sizes, bad frees, merges on both sides
        send_request(bfa_pkg::CMD_ALLOC, 11'd0, 11'd0);        // 1 zero size
        send_request(bfa_pkg::CMD_ALLOC, 11'd1024, 11'd0);     // 2 whole memory
        send_request(bfa_pkg::CMD_ALLOC, 11'd1, 11'd0);        // 3 nothing left
        send_request(bfa_pkg::CMD_FREE, 11'd0, 11'd1);         // 4 free a failed item
        send_request(bfa_pkg::CMD_FREE, 11'd0, 11'd0);         // 5 free item zero
        send_request(bfa_pkg::CMD_FREE, 11'd0, 11'd2047);      // 6 item not numbered yet
        send_request(bfa_pkg::CMD_FREE, 11'd0, 11'd4);         // 7 free a free item
        send_request(bfa_pkg::CMD_FREE, 11'd2047, 11'd2);      // 8 release whole memory
        send_request(bfa_pkg::CMD_FREE, 11'd0, 11'd2);         // 9 double free
        send_request(bfa_pkg::CMD_ALLOC, 11'd2047, 11'd2047);  // 10 too large
        send_request(bfa_pkg::CMD_ALLOC, 11'd10, 11'd0);       // 11 a
        send_request(bfa_pkg::CMD_ALLOC, 11'd20, 11'd0);       // 12 b
        send_request(bfa_pkg::CMD_ALLOC, 11'd10, 11'd0);       // 13 c
        send_request(bfa_pkg::CMD_ALLOC, 11'd5, 11'd0);        // 14 d
        send_request(bfa_pkg::CMD_FREE, 11'd0, 11'd11);        // 15 free a
        send_request(bfa_pkg::CMD_FREE, 11'd0, 11'd13);        // 16 free c
        send_request(bfa_pkg::CMD_ALLOC, 11'd10, 11'd0);       // 17 tie: lowest address
        send_request(bfa_pkg::CMD_FREE, 11'd0, 11'd17);        // 18
        send_request(bfa_pkg::CMD_FREE, 11'd0, 11'd12);        // 19 free b, merge both sides
        send_request(bfa_pkg::CMD_ALLOC, 11'd40, 11'd0);       // 20
        send_request(bfa_pkg::CMD_ALLOC, 11'd1, 11'd0);        // 21

        // sender holds off until every result is back
        drain();

        foreach (totals[i]) begin
            write_total(totals[i]);
            calm = ($urandom_range(0, 2) == 0);
            for (int n = 0; n < 75; n++) begin
                if (n == 37) calm = ~calm;
                random_request();
            end
        end

        // small memory with heavy fragmentation
        write_total(11'd16);
        calm = 0;
        for (int n = 0; n < 35; n++) random_request();

        drain();
        $display("%0d requests sent over 9 memory sizes; %0d grants and %0d refusals checked",
                 sent, sb.grants_seen, sb.refusals_seen);
        if (sb.mismatches == 0) begin
            $display("tb_top passed");
        end else begin
            $display("%0d mismatches", sb.mismatches);
            $display("tb_top failed");
        end
        $finish;
    end
endmodule
`default_nettype wire
